/* src/i8080_pkg.sv */
package i8080_pkg;

  // Flag bit positions in the PSW byte.
  localparam int FlagSignBit   = 7;
  localparam int FlagZeroBit   = 6;
  localparam int FlagAuxBit    = 4;
  localparam int FlagParityBit = 2;
  localparam int FlagCarryBit  = 0;

  // Write counts carried in the result word.
  localparam logic [1:0] WrNone = 2'd0;
  localparam logic [1:0] WrByte = 2'd1;
  localparam logic [1:0] WrPush = 2'd2;

  // Register operand codes.
  localparam logic [2:0] RegB = 3'd0;
  localparam logic [2:0] RegC = 3'd1;
  localparam logic [2:0] RegD = 3'd2;
  localparam logic [2:0] RegE = 3'd3;
  localparam logic [2:0] RegH = 3'd4;
  localparam logic [2:0] RegL = 3'd5;
  localparam logic [2:0] RegM = 3'd6;
  localparam logic [2:0] RegA = 3'd7;

  // Register pair codes.
  localparam logic [1:0] PairBc = 2'd0;
  localparam logic [1:0] PairDe = 2'd1;
  localparam logic [1:0] PairHl = 2'd2;
  localparam logic [1:0] PairSp = 2'd3;

  // Branch condition codes.
  localparam logic [2:0] CondNz = 3'd0;
  localparam logic [2:0] CondZ  = 3'd1;
  localparam logic [2:0] CondNc = 3'd2;
  localparam logic [2:0] CondC  = 3'd3;
  localparam logic [2:0] CondPo = 3'd4;
  localparam logic [2:0] CondPe = 3'd5;
  localparam logic [2:0] CondP  = 3'd6;
  localparam logic [2:0] CondM  = 3'd7;

  // ALU operation codes of the add and subtract group.
  localparam logic [1:0] AluAdd = 2'd0;
  localparam logic [1:0] AluAdc = 2'd1;
  localparam logic [1:0] AluSub = 2'd2;
  localparam logic [1:0] AluSbb = 2'd3;

  // Single opcodes.
  localparam logic [7:0] OpNop  = 8'h00;
  localparam logic [7:0] OpLxiB = 8'h01;
  localparam logic [7:0] OpJmp  = 8'hc3;
  localparam logic [7:0] OpCall = 8'hcd;

  // Opcode groups, each a mask and the value under that mask.
  localparam logic [7:0] MaskPair   = 8'hcf;
  localparam logic [7:0] OpInxRp    = 8'h03;
  localparam logic [7:0] OpDcxRp    = 8'h0b;
  localparam logic [7:0] OpDadRp    = 8'h09;
  localparam logic [7:0] MaskIncDec = 8'hc6;
  localparam logic [7:0] OpIncDec   = 8'h04;
  localparam logic [7:0] MaskAluReg = 8'he0;
  localparam logic [7:0] OpAluReg   = 8'h80;
  localparam logic [7:0] MaskAluImm = 8'he7;
  localparam logic [7:0] OpAluImm   = 8'hc6;
  localparam logic [7:0] MaskCond   = 8'hc7;
  localparam logic [7:0] OpJcc      = 8'hc2;
  localparam logic [7:0] OpCcc      = 8'hc4;

  // Result word fields.
  typedef struct packed {
    logic        unimplemented;
    logic [15:0] hl_out;
    logic [7:0]  flags_out;
    logic [7:0]  acc_out;
    logic [7:0]  write_high_byte;
    logic [7:0]  write_low_byte;
    logic [15:0] write_address;
    logic [1:0]  write_count;
    logic [15:0] next_pc;
  } result_t;

  // Sum of an 8-bit add with the carries out of bit 3 and bit 7.
  typedef struct packed {
    logic [7:0] sum;
    logic       aux;
    logic       carry;
  } add_t;

  function automatic add_t add8(input logic [7:0] x, input logic [7:0] y, input logic cin);
    add_t r;
    logic [4:0] lo;
    logic [8:0] s;
    lo = {1'b0, x[3:0]} + {1'b0, y[3:0]} + {4'd0, cin};
    s = {1'b0, x} + {1'b0, y} + {8'd0, cin};
    r.sum = s[7:0];
    r.aux = lo[4];
    r.carry = s[8];
    return r;
  endfunction

endpackage

/* src/i8080_instruction_execute_top.sv */
// 8080 instruction execute unit.
// Input channel s_axis: one word per fetched instruction. tdata holds, from the
// lowest bit up, the opcode, the byte after it, the second byte after it, and
// the memory byte at address HL.
// Output channel m_axis: one word per instruction with the next PC, the memory
// write request (count, address, low and high byte), A, flags, HL and an
// unimplemented flag for opcodes outside the covered set.
// Each instruction is decoded and executed in the cycle it is accepted, and its
// result word is registered, so m_axis tvalid rises in the cycle after its
// acceptance. One instruction per cycle is sustained while the receiver does
// not stall, since register state is updated at the same edge as the result.
// When the receiver stalls, the result word holds; a new instruction is still
// taken as long as the result register is empty or drained in that cycle.
// Reset clears all registers, SP, PC and flags to zero and empties the output.
module i8080_instruction_execute_top (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // opcode, operand_low, operand_high, hl_memory_byte
  input  logic [31:0]  s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // next_pc, write_count, write_address, write_low_byte, write_high_byte,
  // acc_out, flags_out, hl_out, unimplemented (then zero fill)
  output logic [87:0]  m_axis_tdata
);

  logic [7:0]  acc, reg_b, reg_c, reg_d, reg_e, reg_h, reg_l;
  logic [15:0] sp, pc;
  logic        f_z, f_s, f_p, f_cy, f_ac;

  logic [7:0]  acc_next, b_next, c_next, d_next, e_next, h_next, l_next;
  logic [15:0] sp_next, pc_next;
  logic        z_next, s_next, p_next, cy_next, ac_next;

  i8080_pkg::result_t res, res_next;
  logic out_valid;
  logic take;

  logic [7:0]  opc, lo, hi, mem;
  logic [15:0] target, hl;
  logic [7:0]  src, pair_op, alu_y;
  logic [15:0] pair_val, pair_res;
  logic [16:0] dad_sum;
  logic        cond, alu_cin;
  i8080_pkg::add_t ar;

  assign opc = s_axis_tdata[7:0];
  assign lo  = s_axis_tdata[15:8];
  assign hi  = s_axis_tdata[23:16];
  assign mem = s_axis_tdata[31:24];
  assign target = {hi, lo};
  assign hl = {reg_h, reg_l};

  assign s_axis_tready = !out_valid || m_axis_tready;
  assign take = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata = {5'd0, res};

  // Register operand select; the M code reads the memory byte.
  always_comb begin
    unique case ((opc[7:6] == 2'b10) ? opc[2:0] : opc[5:3])
      i8080_pkg::RegB: src = reg_b;
      i8080_pkg::RegC: src = reg_c;
      i8080_pkg::RegD: src = reg_d;
      i8080_pkg::RegE: src = reg_e;
      i8080_pkg::RegH: src = reg_h;
      i8080_pkg::RegL: src = reg_l;
      i8080_pkg::RegM: src = mem;
      default:         src = acc;
    endcase
  end

  // Register pair select for INX, DCX and DAD.
  always_comb begin
    unique case (opc[5:4])
      i8080_pkg::PairBc: pair_val = {reg_b, reg_c};
      i8080_pkg::PairDe: pair_val = {reg_d, reg_e};
      i8080_pkg::PairHl: pair_val = hl;
      default:           pair_val = sp;
    endcase
  end

  // Condition code test.
  always_comb begin
    unique case (opc[5:3])
      i8080_pkg::CondNz: cond = !f_z;
      i8080_pkg::CondZ:  cond = f_z;
      i8080_pkg::CondNc: cond = !f_cy;
      i8080_pkg::CondC:  cond = f_cy;
      i8080_pkg::CondPo: cond = !f_p;
      i8080_pkg::CondPe: cond = f_p;
      i8080_pkg::CondP:  cond = !f_s;
      default:           cond = f_s;
    endcase
  end

  // One shared 8-bit adder serves INR/DCR and the ALU group.
  always_comb begin
    pair_op = src;
    alu_y = 8'h01;
    alu_cin = 1'b0;
    if (opc[7:6] == 2'b00) begin
      alu_y = opc[0] ? 8'hff : 8'h01;
    end else begin
      if (opc[7:6] == 2'b11) pair_op = lo;
      alu_y = opc[4] ? ~pair_op : pair_op;
      alu_cin = opc[4] ? !(opc[3] && f_cy) : (opc[3] && f_cy);
    end
    ar = i8080_pkg::add8((opc[7:6] == 2'b00) ? src : acc, alu_y, alu_cin);
  end

  assign pair_res = opc[3] ? pair_val - 16'd1 : pair_val + 16'd1;
  assign dad_sum = {1'b0, hl} + {1'b0, pair_val};

  // Instruction decode and next state.
  always_comb begin
    acc_next = acc; b_next = reg_b; c_next = reg_c; d_next = reg_d;
    e_next = reg_e; h_next = reg_h; l_next = reg_l;
    sp_next = sp; z_next = f_z; s_next = f_s; p_next = f_p;
    cy_next = f_cy; ac_next = f_ac;
    pc_next = pc + 16'd1;
    res_next = '0;
    if (opc == i8080_pkg::OpNop) begin
    end else if (opc == i8080_pkg::OpLxiB) begin
      b_next = hi; c_next = lo;
      pc_next = pc + 16'd3;
    end else if ((opc & i8080_pkg::MaskPair) == i8080_pkg::OpInxRp ||
                 (opc & i8080_pkg::MaskPair) == i8080_pkg::OpDcxRp) begin
      unique case (opc[5:4])
        i8080_pkg::PairBc: {b_next, c_next} = pair_res;
        i8080_pkg::PairDe: {d_next, e_next} = pair_res;
        i8080_pkg::PairHl: {h_next, l_next} = pair_res;
        default:           sp_next = pair_res;
      endcase
    end else if ((opc & i8080_pkg::MaskPair) == i8080_pkg::OpDadRp) begin
      cy_next = dad_sum[16];
      {h_next, l_next} = dad_sum[15:0];
    end else if ((opc & i8080_pkg::MaskIncDec) == i8080_pkg::OpIncDec) begin
      ac_next = ar.aux; s_next = ar.sum[7]; z_next = (ar.sum == 8'd0);
      p_next = ~^ar.sum;
      unique case (opc[5:3])
        i8080_pkg::RegB: b_next = ar.sum;
        i8080_pkg::RegC: c_next = ar.sum;
        i8080_pkg::RegD: d_next = ar.sum;
        i8080_pkg::RegE: e_next = ar.sum;
        i8080_pkg::RegH: h_next = ar.sum;
        i8080_pkg::RegL: l_next = ar.sum;
        i8080_pkg::RegM: begin
          res_next.write_count = i8080_pkg::WrByte;
          res_next.write_address = hl;
          res_next.write_low_byte = ar.sum;
        end
        default:         acc_next = ar.sum;
      endcase
    end else if ((opc & i8080_pkg::MaskAluReg) == i8080_pkg::OpAluReg ||
                 (opc & i8080_pkg::MaskAluImm) == i8080_pkg::OpAluImm) begin
      acc_next = ar.sum;
      ac_next = ar.aux; s_next = ar.sum[7]; z_next = (ar.sum == 8'd0);
      p_next = ~^ar.sum;
      cy_next = ar.carry ^ opc[4];
      if (opc[7:6] == 2'b11) pc_next = pc + 16'd2;
    end else if (opc == i8080_pkg::OpJmp ||
                 (opc & i8080_pkg::MaskCond) == i8080_pkg::OpJcc) begin
      pc_next = (opc == i8080_pkg::OpJmp || cond) ? target : pc + 16'd3;
    end else if (opc == i8080_pkg::OpCall ||
                 (opc & i8080_pkg::MaskCond) == i8080_pkg::OpCcc) begin
      pc_next = pc + 16'd3;
      if (opc == i8080_pkg::OpCall || cond) begin
        sp_next = sp - 16'd2;
        res_next.write_count = i8080_pkg::WrPush;
        res_next.write_address = sp - 16'd2;
        res_next.write_low_byte = pc_next[7:0];
        res_next.write_high_byte = pc_next[15:8];
        pc_next = target;
      end
    end else begin
      res_next.unimplemented = 1'b1;
      pc_next = pc;
    end
    res_next.next_pc = pc_next;
    res_next.acc_out = acc_next;
    res_next.hl_out = {h_next, l_next};
    res_next.flags_out = '0;
    res_next.flags_out[i8080_pkg::FlagSignBit] = s_next;
    res_next.flags_out[i8080_pkg::FlagZeroBit] = z_next;
    res_next.flags_out[i8080_pkg::FlagAuxBit] = ac_next;
    res_next.flags_out[i8080_pkg::FlagParityBit] = p_next;
    res_next.flags_out[i8080_pkg::FlagCarryBit] = cy_next;
  end

  // Architectural state and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0; reg_b <= '0; reg_c <= '0; reg_d <= '0; reg_e <= '0;
      reg_h <= '0; reg_l <= '0; sp <= '0; pc <= '0;
      f_z <= 1'b0; f_s <= 1'b0; f_p <= 1'b0; f_cy <= 1'b0; f_ac <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (take) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
      if (take) begin
        acc <= acc_next; reg_b <= b_next; reg_c <= c_next; reg_d <= d_next;
        reg_e <= e_next; reg_h <= h_next; reg_l <= l_next;
        sp <= sp_next; pc <= pc_next;
        f_z <= z_next; f_s <= s_next; f_p <= p_next; f_cy <= cy_next; f_ac <= ac_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) res <= res_next;
  end

`ifndef SYNTHESIS
  // A stalled result word must not be overwritten.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result word changed while stalled");

  // The reported PC always matches the architectural PC after acceptance.
  a_pc: assert property (@(posedge clk) disable iff (rst)
    take |=> res.next_pc == pc)
    else $error("reported PC differs from PC register");

  // An unimplemented opcode leaves the PC where it was.
  a_unimpl: assert property (@(posedge clk) disable iff (rst)
    take && res_next.unimplemented |=> pc == $past(pc))
    else $error("unimplemented opcode moved PC");
`endif

endmodule
